/* sv/ffsa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared types, widths and status codes of the first-fit segment allocator.
// ----------------------------------------------------------------------------
package ffsa_pkg;

   localparam int OFF_W   = 25;
   localparam int LEN_W   = 25;
   localparam int SIZE_W  = 25;
   localparam int ADDR_W  = 32;
   localparam int GRANT_W = 26;
   localparam int STAT_W  = 3;

   localparam logic [31:0] DEF_HEAP_BASE    = 32'd16777216;
   localparam int          DEF_HEAP_BYTES   = 16777216;
   localparam int          DEF_PAGE_BYTES   = 4096;
   localparam int          DEF_HEADER_BYTES = 12;
   localparam int          DEF_MAX_SEGMENTS = 64;

   localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
   localparam logic [STAT_W-1:0] ST_NOOP    = 3'd1;
   localparam logic [STAT_W-1:0] ST_NOFIT   = 3'd2;
   localparam logic [STAT_W-1:0] ST_FULL    = 3'd3;
   localparam logic [STAT_W-1:0] ST_UNKNOWN = 3'd4;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef struct packed {
      logic [OFF_W-1:0] offset;
      logic [LEN_W-1:0] length;
      logic             in_use;
   } entry_type;

endpackage

/* sv/ffsa_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsa_mem
// Segment table memory: one write and one registered read per cycle. Entry 0
// reads as the initial whole-heap segment until it is first written.
// ----------------------------------------------------------------------------
module ffsa_mem #(
   parameter int DEPTH      = ffsa_pkg::DEF_MAX_SEGMENTS,
   parameter int INIT_LEN   = ffsa_pkg::DEF_HEAP_BYTES - ffsa_pkg::DEF_HEADER_BYTES
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output ffsa_pkg::entry_type       rd_data,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  ffsa_pkg::entry_type       wr_data
);
   import ffsa_pkg::*;

   localparam int IW = $clog2(DEPTH);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;
   logic      init_ff;
   logic      rd_init_ff;
   entry_type init_entry;

   assign init_entry = '{offset: '0, length: LEN_W'(INIT_LEN), in_use: 1'b0};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff    <= 1'b1;
         rd_init_ff <= 1'b0;
      end else begin
         rd_init_ff <= init_ff && (rd_addr == IW'(0));
         if (wr_en && wr_addr == IW'(0)) begin
            init_ff <= 1'b0;
         end
      end
   end

   assign rd_data = rd_init_ff ? init_entry : rd_data_ff;

endmodule

/* sv/first_fit_segment_allocator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_top
// First-fit heap allocator over an address-ordered segment table in memory.
// ----------------------------------------------------------------------------
// Requests enter on req_* (valid/ready); each gives exactly one response on
// rsp_* (valid/ready). req_opcode 0 allocates req_request_size bytes, rounded
// up to a page; 1 frees the region at req_region_address.
// One request is worked at a time. The table is walked one entry at a time
// through the memory's registered read port, each entry read in one state
// and checked in the next: a search visits entries in order, a split moves
// each entry above the hit up by one, and a free adds a compaction pass over
// every table entry.
// After reset the table holds one free segment covering the heap minus one
// header; no clearing pass is needed. A finished response sits in the output
// register until taken; while it waits, the next request is already accepted
// and worked, and its response waits in turn for the output register.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator_top #(
   parameter logic [31:0] HEAP_BASE    = ffsa_pkg::DEF_HEAP_BASE,
   parameter int          HEAP_BYTES   = ffsa_pkg::DEF_HEAP_BYTES,
   parameter int          PAGE_BYTES   = ffsa_pkg::DEF_PAGE_BYTES,
   parameter int          HEADER_BYTES = ffsa_pkg::DEF_HEADER_BYTES,
   parameter int          MAX_SEGMENTS = ffsa_pkg::DEF_MAX_SEGMENTS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_opcode,
   input  logic [ffsa_pkg::SIZE_W-1:0]   req_request_size,
   input  logic [ffsa_pkg::ADDR_W-1:0]   req_region_address,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ffsa_pkg::GRANT_W-1:0]  rsp_granted_address,
   output logic [ffsa_pkg::STAT_W-1:0]   rsp_status
);
   import ffsa_pkg::*;

   localparam int IW = $clog2(MAX_SEGMENTS);
   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   localparam int NW = GRANT_W;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_SRCH_RD = 4'd1;
   localparam logic [3:0] S_SRCH_CK = 4'd2;
   localparam logic [3:0] S_SHFT_RD = 4'd3;
   localparam logic [3:0] S_SHFT_WR = 4'd4;
   localparam logic [3:0] S_INS_T   = 4'd5;
   localparam logic [3:0] S_INS_H   = 4'd6;
   localparam logic [3:0] S_MRG_RD  = 4'd7;
   localparam logic [3:0] S_MRG_CK  = 4'd8;
   localparam logic [3:0] S_MRG_FIN = 4'd9;
   localparam logic [3:0] S_DONE    = 4'd10;

   logic [3:0]         state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      wptr_ff, wptr_in;
   logic               op_ff, op_in;
   logic [NW-1:0]      need_ff, need_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   entry_type          hit_ff, hit_in;
   logic [CW-1:0]      hit_idx_ff, hit_idx_in;
   entry_type          acc_ff, acc_in;
   logic [GRANT_W-1:0] res_grant_ff, res_grant_in;
   logic [STAT_W-1:0]  res_stat_ff, res_stat_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [GRANT_W-1:0] rsp_grant_ff, rsp_grant_in;
   logic [STAT_W-1:0]  rsp_stat_ff, rsp_stat_in;

   logic [IW-1:0] rd_addr;
   entry_type     rd_data;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   entry_type     wr_data;

   logic [NW:0]     round_sum;
   logic            fits;
   logic            split;
   logic [32:0]     data_start;
   logic            addr_hit;
   logic [CW-1:0]   idx_next;
   logic [CW-1:0]   j_less;

   ffsa_mem #(
      .DEPTH    (MAX_SEGMENTS),
      .INIT_LEN (HEAP_BYTES - HEADER_BYTES)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // Page size is a power of two, so rounding up is an add and a mask.
   assign round_sum = (NW+1)'(req_request_size) + (NW+1)'(PAGE_BYTES - 1);
   assign fits  = !rd_data.in_use && ((NW'(rd_data.length)) >= need_ff);
   assign split = (27'(rd_data.length)) >
                  (27'(need_ff) + 27'(HEADER_BYTES) + 27'(PAGE_BYTES));
   assign data_start = 33'(HEAP_BASE) + 33'(rd_data.offset) + 33'(HEADER_BYTES);
   assign addr_hit   = (data_start == 33'(addr_ff));
   assign idx_next   = idx_ff + CW'(1);
   assign j_less     = idx_ff - CW'(1);

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      wptr_in      = wptr_ff;
      op_in        = op_ff;
      need_in      = need_ff;
      addr_in      = addr_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      acc_in       = acc_ff;
      res_grant_in = res_grant_ff;
      res_stat_in  = res_stat_ff;
      rd_addr      = idx_ff[IW-1:0];
      wr_en        = 1'b0;
      wr_addr      = idx_ff[IW-1:0];
      wr_data      = rd_data;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in        = req_opcode;
               need_in      = round_sum[NW-1:0] & ~NW'(PAGE_BYTES - 1);
               addr_in      = req_region_address;
               idx_in       = '0;
               res_grant_in = '0;
               if ((req_opcode == OP_ALLOC && req_request_size == '0) ||
                   (req_opcode == OP_FREE && req_region_address == '0)) begin
                  res_stat_in = ST_NOOP;
                  state_in    = S_DONE;
               end else begin
                  state_in = S_SRCH_RD;
               end
            end
         end
         S_SRCH_RD: begin
            rd_addr  = idx_ff[IW-1:0];
            state_in = S_SRCH_CK;
         end
         S_SRCH_CK: begin
            if (op_ff == OP_ALLOC && fits) begin
               if (split && count_ff >= CW'(MAX_SEGMENTS)) begin
                  res_stat_in = ST_FULL;
                  state_in    = S_DONE;
               end else if (split) begin
                  hit_in     = rd_data;
                  hit_idx_in = idx_ff;
                  idx_in     = count_ff;
                  state_in   = (count_ff > idx_next) ? S_SHFT_RD : S_INS_T;
               end else begin
                  wr_en        = 1'b1;
                  wr_data      = rd_data;
                  wr_data.in_use = 1'b1;
                  res_grant_in = GRANT_W'(data_start);
                  res_stat_in  = ST_OK;
                  state_in     = S_DONE;
               end
            end else if (op_ff == OP_FREE && addr_hit) begin
               wr_en          = 1'b1;
               wr_data        = rd_data;
               wr_data.in_use = 1'b0;
               res_stat_in    = ST_OK;
               idx_in         = '0;
               wptr_in        = '0;
               state_in       = S_MRG_RD;
            end else if (idx_next == count_ff) begin
               res_stat_in = (op_ff == OP_ALLOC) ? ST_NOFIT : ST_UNKNOWN;
               state_in    = S_DONE;
            end else begin
               idx_in   = idx_next;
               state_in = S_SRCH_RD;
            end
         end
         // Move entries up by one, from the top down to just above the hit.
         S_SHFT_RD: begin
            rd_addr  = j_less[IW-1:0];
            state_in = S_SHFT_WR;
         end
         S_SHFT_WR: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff[IW-1:0];
            wr_data  = rd_data;
            idx_in   = j_less;
            state_in = (j_less > hit_idx_ff + CW'(1)) ? S_SHFT_RD : S_INS_T;
         end
         S_INS_T: begin
            wr_en          = 1'b1;
            wr_addr        = IW'(hit_idx_ff + CW'(1));
            wr_data.offset = hit_ff.offset + OFF_W'(HEADER_BYTES) + need_ff[OFF_W-1:0];
            wr_data.length = hit_ff.length - need_ff[LEN_W-1:0] - LEN_W'(HEADER_BYTES);
            wr_data.in_use = 1'b0;
            state_in       = S_INS_H;
         end
         S_INS_H: begin
            wr_en          = 1'b1;
            wr_addr        = hit_idx_ff[IW-1:0];
            wr_data.offset = hit_ff.offset;
            wr_data.length = need_ff[LEN_W-1:0];
            wr_data.in_use = 1'b1;
            count_in       = count_ff + CW'(1);
            res_grant_in   = GRANT_W'(HEAP_BASE) + GRANT_W'(hit_ff.offset)
                             + GRANT_W'(HEADER_BYTES);
            res_stat_in    = ST_OK;
            state_in       = S_DONE;
         end
         // Compaction pass: runs of free segments fold into their first entry.
         S_MRG_RD: begin
            rd_addr  = idx_ff[IW-1:0];
            state_in = S_MRG_CK;
         end
         S_MRG_CK: begin
            if (idx_ff == '0) begin
               acc_in = rd_data;
            end else if (!acc_ff.in_use && !rd_data.in_use) begin
               acc_in.length = acc_ff.length + rd_data.length + LEN_W'(HEADER_BYTES);
            end else begin
               wr_en   = 1'b1;
               wr_addr = wptr_ff[IW-1:0];
               wr_data = acc_ff;
               wptr_in = wptr_ff + CW'(1);
               acc_in  = rd_data;
            end
            idx_in   = idx_next;
            state_in = (idx_next == count_ff) ? S_MRG_FIN : S_MRG_RD;
         end
         S_MRG_FIN: begin
            wr_en    = 1'b1;
            wr_addr  = wptr_ff[IW-1:0];
            wr_data  = acc_ff;
            count_in = wptr_ff + CW'(1);
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_grant_in = rsp_grant_ff;
      rsp_stat_in  = rsp_stat_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == S_DONE && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_in = 1'b1;
         rsp_grant_in = res_grant_ff;
         rsp_stat_in  = res_stat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= CW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      wptr_ff      <= wptr_in;
      op_ff        <= op_in;
      need_ff      <= need_in;
      addr_ff      <= addr_in;
      hit_ff       <= hit_in;
      hit_idx_ff   <= hit_idx_in;
      acc_ff       <= acc_in;
      res_grant_ff <= res_grant_in;
      res_stat_ff  <= res_stat_in;
      rsp_grant_ff <= rsp_grant_in;
      rsp_stat_ff  <= rsp_stat_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_granted_address = rsp_grant_ff;
   assign rsp_status          = rsp_stat_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff >= CW'(1) && count_ff <= CW'(MAX_SEGMENTS))
      else $error("segment count out of range");

   a_no_grant_on_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_granted_address == '0)
      else $error("grant given with a failing status");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff != S_IDLE)
      else $error("accepted request did not start");

   a_count_only_on_commit: assert property (@(posedge clock) disable iff (reset)
      count_ff != $past(count_ff) |-> $past(state_ff) == S_INS_H ||
                                     $past(state_ff) == S_MRG_FIN)
      else $error("segment count changed outside a table update");

endmodule
